/* rtl/assert_macros.svh */
// Assertion helpers for the key matrix block.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KMDR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key matrix check failed");

// Consequent checked in the cycle after the antecedent.
`define KMDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key matrix check failed");

`endif

/* rtl/kmdr_pkg.sv */
package kmdr_pkg;

  // Matrix size and derived address width
  localparam int KEY_COUNT = 64;
  localparam int KEY_AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // Fixed field widths
  localparam int IDX_W  = 6;
  localparam int CODE_W = 16;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 8;

  // Report queue
  localparam int               QUEUE_LEN  = 6;
  localparam logic [SLOT_W-1:0] EMPTY_SLOT = 8'hFF;

  // Release counter load value and fire value
  localparam logic [CNT_W-1:0] REL_LOAD = 8'h80;
  localparam logic [CNT_W-1:0] REL_FIRE = 8'h01;

  // Layout code fields
  localparam logic [CODE_W-1:0] CODE_HI_MASK = 16'hFF00;
  localparam logic [CODE_W-1:0] CODE_MOD     = 16'h0100;
  localparam logic [CODE_W-1:0] CODE_LOCK    = 16'h0400;
  localparam logic [CODE_W-1:0] CODE_LO_MASK = 16'h00FF;

  typedef logic [QUEUE_LEN-1:0][SLOT_W-1:0] slot_vec_t;

  typedef enum logic [1:0] {
    KC_REGULAR,
    KC_MODIFIER,
    KC_LOCK
  } key_class_t;

  // One key's entry in the state memory
  typedef struct packed {
    logic              prev;
    logic              held;
    logic [CNT_W-1:0]  cnt;
    logic [CODE_W-1:0] code;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

  // Update request from the sequencer to the report state
  typedef struct packed {
    logic              press;
    logic              release_key;
    logic [SLOT_W-1:0] key;
    logic [CODE_W-1:0] code;
  } rpt_op_t;

  function automatic key_class_t classify(input logic [CODE_W-1:0] code);
    key_class_t kc;
    if ((code & CODE_HI_MASK) == CODE_MOD) begin
      kc = KC_MODIFIER;
    end else if ((code & CODE_LOCK) == CODE_LOCK) begin
      kc = KC_LOCK;
    end else begin
      kc = KC_REGULAR;
    end
    return kc;
  endfunction

endpackage

/* rtl/kmdr_ram.sv */
module kmdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/kmdr_report.sv */
module kmdr_report (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmdr_pkg::rpt_op_t      op,
  output kmdr_pkg::slot_vec_t    slots_q,
  output logic [7:0]             mask_q,
  output kmdr_pkg::slot_vec_t    slots_nxt,
  output logic [7:0]             mask_nxt
);
  import kmdr_pkg::*;

  slot_vec_t         slots_r;
  logic [7:0]        mask_r;
  key_class_t        kc;
  logic [7:0]        bits;
  logic [QUEUE_LEN-1:0] hit;
  logic [QUEUE_LEN-1:0] hit_pre;

  assign kc   = classify(op.code);
  assign bits = 8'(op.code & CODE_LO_MASK);

  // Locate the key in the queue; everything from the first hit on moves up
  always_comb begin
    for (int i = 0; i < QUEUE_LEN; i++) begin
      hit[i] = (slots_r[i] == op.key);
    end
    hit_pre[0] = hit[0];
    for (int i = 1; i < QUEUE_LEN; i++) begin
      hit_pre[i] = hit_pre[i-1] | hit[i];
    end
  end

  // Next queue and modifier mask
  always_comb begin
    slots_nxt = slots_r;
    mask_nxt  = mask_r;
    if (op.press) begin
      case (kc)
        KC_MODIFIER: mask_nxt = mask_r | bits;
        KC_REGULAR: begin
          for (int i = QUEUE_LEN - 1; i > 0; i--) begin
            slots_nxt[i] = slots_r[i-1];
          end
          slots_nxt[0] = op.key;
        end
        default: ;
      endcase
    end else if (op.release_key) begin
      case (kc)
        KC_MODIFIER: mask_nxt = mask_r & ~bits;
        KC_REGULAR: begin
          for (int i = 0; i < QUEUE_LEN - 1; i++) begin
            if (hit_pre[i]) begin
              slots_nxt[i] = slots_r[i+1];
            end
          end
          if (hit_pre[QUEUE_LEN-1]) begin
            slots_nxt[QUEUE_LEN-1] = EMPTY_SLOT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= {QUEUE_LEN{EMPTY_SLOT}};
      mask_r  <= '0;
    end else begin
      slots_r <= slots_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign slots_q = slots_r;
  assign mask_q  = mask_r;

endmodule

/* rtl/key_matrix_debounce_rollover_unit.sv */
// Key matrix debounce with a six-key rollover report. Per-key state (last
// level, held flag, release counter, captured layout code) lives in one
// KEY_COUNT-entry RAM with registered read; the report queue and modifier
// mask live in registers. After reset the block runs a clearing pass over
// all KEY_COUNT RAM entries with in_tready low. A scan sample is a RAM
// read, then write-back and report. A timer tick walks the RAM one key per
// cycle while the result side does not stall a report. A tick's reports
// leave one behind the walk, so the final one (out_tlast high) goes out
// once the walk is done. A finished report sits in the output register while
// the next item is already accepted.
`include "assert_macros.svh"

module key_matrix_debounce_rollover_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_index[5:0], key_level[6], key_code[22:7], zero pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // slot_a..slot_f (8b each), modifier_mask[55:48]
  output logic        out_tlast   // last_report
);
  import kmdr_pkg::*;

  localparam int CMP_W = ((KEY_AW > IDX_W) ? KEY_AW : IDX_W) + 1;
  localparam logic [KEY_AW-1:0] LAST_KEY = KEY_AW'(KEY_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_FLUSH
  } state_t;

  state_t              state_r, state_nxt;
  logic [KEY_AW-1:0]   walk_r, walk_nxt;
  logic [KEY_AW-1:0]   key_addr_r, key_addr_nxt;
  logic                level_r, level_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [55:0]         out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  // Input fields
  logic [IDX_W-1:0]    in_key;
  logic                in_level;
  logic [CODE_W-1:0]   in_code;
  logic [KEY_AW-1:0]   in_addr;
  logic                in_range;

  // RAM port signals
  logic                wr_en;
  logic [KEY_AW-1:0]   wr_addr;
  key_entry_t          wr_entry;
  logic [KEY_AW-1:0]   rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  key_entry_t          rd_entry;

  // Report state
  rpt_op_t             op;
  slot_vec_t           slots_q, slots_nxt;
  logic [7:0]          mask_q, mask_nxt;

  // Per-cycle decode
  logic out_free;
  logic rise, fall, press;
  logic rel, stall;

  assign in_key   = in_tdata[5:0];
  assign in_level = in_tdata[6];
  assign in_code  = in_tdata[22:7];
  assign in_addr  = KEY_AW'(in_key);
  assign in_range = CMP_W'(in_key) < CMP_W'(KEY_COUNT);

  assign rd_entry = key_entry_t'(rd_data);
  assign out_free = !out_valid_r || out_tready;

  assign rise  = level_r & ~rd_entry.prev;
  assign fall  = ~level_r & rd_entry.prev;
  assign press = rise & ~rd_entry.held;
  assign rel   = (rd_entry.cnt == REL_FIRE);
  assign stall = rel && pend_r && !out_free;

  kmdr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_COUNT)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kmdr_report u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .slots_q   (slots_q),
    .mask_q    (mask_q),
    .slots_nxt (slots_nxt),
    .mask_nxt  (mask_nxt)
  );

  // Sequencer: clear sweep, scan read-modify-write, tick walk, final report
  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    key_addr_nxt  = key_addr_r;
    level_nxt     = level_r;
    code_nxt      = code_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = walk_r;
    wr_entry      = rd_entry;
    rd_addr       = walk_r;
    op            = '0;

    case (state_r)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_entry = '0;
        if (walk_r == LAST_KEY) begin
          walk_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = KEY_AW'(walk_r + KEY_AW'(1));
        end
      end

      ST_IDLE: begin
        rd_addr = in_tuser ? '0 : in_addr;
        if (in_tvalid) begin
          if (in_tuser) begin
            walk_nxt  = '0;
            state_nxt = ST_TICK;
          end else if (in_range) begin
            key_addr_nxt = in_addr;
            level_nxt    = in_level;
            code_nxt     = in_code;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        rd_addr = key_addr_r;
        wr_addr = key_addr_r;
        if (!press || out_free) begin
          wr_en         = 1'b1;
          wr_entry.prev = level_r;
          if (rise) begin
            wr_entry.cnt = '0;
          end
          if (press) begin
            wr_entry.held = 1'b1;
            wr_entry.code = code_r;
          end
          if (fall) begin
            wr_entry.cnt = REL_LOAD;
          end
          op.press = press;
          op.key   = SLOT_W'(key_addr_r);
          op.code  = code_r;
          if (press) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {mask_nxt, slots_nxt};
            out_last_nxt  = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_TICK: begin
        if (!stall) begin
          wr_en = 1'b1;
          if (rel) begin
            wr_entry.held = 1'b0;
            wr_entry.cnt  = '0;
            pend_nxt      = 1'b1;
          end else begin
            wr_entry.cnt = rd_entry.cnt >> 1;
          end
          op.release_key = rel;
          op.key         = SLOT_W'(walk_r);
          op.code        = rd_entry.code;
          // Earlier release's report goes out now, known not to be the last
          if (rel && pend_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {mask_q, slots_q};
            out_last_nxt  = 1'b0;
          end
          if (walk_r == LAST_KEY) begin
            state_nxt = ST_FLUSH;
          end else begin
            walk_nxt = KEY_AW'(walk_r + KEY_AW'(1));
            rd_addr  = KEY_AW'(walk_r + KEY_AW'(1));
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {mask_q, slots_q};
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_addr_r <= key_addr_nxt;
    level_r    <= level_nxt;
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A held-back tick report never survives past the walk
  `KMDR_ASSERT_NOW(a_pend_in_tick, pend_r, (state_r == ST_TICK) || (state_r == ST_FLUSH))
  // No new item while a tick report is still held back
  `KMDR_ASSERT_NOW(a_ready_no_pend, in_tready, !pend_r)
  // The clearing pass produces no reports
  `KMDR_ASSERT_NOW(a_clear_quiet, state_r == ST_CLEAR, !out_valid_r)
  // A report loaded during the walk is never marked final
  `KMDR_ASSERT_NEXT(a_tick_not_last, (state_r == ST_TICK) && out_free && rel && pend_r,
                    out_valid_r && !out_last_r)

endmodule

/* sim/kmdr_report_checker.sv */
`timescale 1ns / 100ps

// Watches both channels, tracks per-key debounce state and the rollover
// queue, and compares every report with the oldest predicted one.
module kmdr_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,    // key_index[5:0], key_level[6], key_code[22:7], zero pad
  input  logic        in_tuser,    // cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,   // slot_a..slot_f (8b each), modifier_mask[55:48]
  input  logic        out_tlast,   // last_report
  output int          mismatches,
  output int          reports_due
);
  import kmdr_pkg::*;

  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic [SLOT_W-1:0] mods;
    slot_vec_t         slots;
    logic              last;
  } report_t;

  report_t due_q[$];

  // Predicted per-key state
  logic              key_level  [KEY_COUNT];
  logic              key_held   [KEY_COUNT];
  logic [CNT_W-1:0]  release_cnt[KEY_COUNT];
  logic [CODE_W-1:0] held_code  [KEY_COUNT];

  // Predicted report state
  slot_vec_t         rollover;
  logic [SLOT_W-1:0] mod_bits;

  // Last report of the current item is held back until its flag is known
  report_t staged;
  bit      staged_ok;

  function automatic key_class_t code_kind(input logic [CODE_W-1:0] code);
    key_class_t kind;
    kind = KC_REGULAR;
    if (code[15:8] == CODE_MOD[15:8]) begin
      kind = KC_MODIFIER;
    end else if ((code & CODE_LOCK) != '0) begin
      kind = KC_LOCK;
    end
    return kind;
  endfunction

  task automatic stage_report();
    if (staged_ok) begin
      due_q.push_back(staged);
    end
    staged.mods  = mod_bits;
    staged.slots = rollover;
    staged.last  = 1'b0;
    staged_ok    = 1'b1;
  endtask

  task automatic press_key(input int key, input logic [CODE_W-1:0] code);
    key_held[key]    = 1'b1;
    release_cnt[key] = '0;
    held_code[key]   = code;
    case (code_kind(code))
      KC_MODIFIER: mod_bits = mod_bits | code[7:0];
      KC_REGULAR:  rollover = {rollover[QUEUE_LEN-2:0], SLOT_W'(key)};
      default: ;
    endcase
  endtask

  task automatic release_key(input int key);
    logic [CODE_W-1:0] code;
    int pos;
    int i;
    code             = held_code[key];
    key_held[key]    = 1'b0;
    release_cnt[key] = '0;
    case (code_kind(code))
      KC_MODIFIER: mod_bits = mod_bits & ~code[7:0];
      KC_REGULAR: begin
        // first matching slot, newest side
        pos = -1;
        for (i = QUEUE_LEN - 1; i >= 0; i--) begin
          if (rollover[i] == SLOT_W'(key)) pos = i;
        end
        if (pos >= 0) begin
          for (i = pos; i < QUEUE_LEN - 1; i++) rollover[i] = rollover[i+1];
          rollover[QUEUE_LEN-1] = EMPTY_SLOT;
        end
      end
      default: ;
    endcase
  endtask

  // Predict the reports of one accepted item
  task automatic apply_item(input logic cmd, input logic [IDX_W-1:0] idx, input logic lvl,
                            input logic [CODE_W-1:0] code);
    int k;
    staged_ok = 1'b0;
    if (!cmd) begin
      if (lvl && !key_level[idx]) begin
        if (!key_held[idx]) begin
          press_key(int'(idx), code);
          stage_report();
        end else begin
          release_cnt[idx] = '0;
        end
      end else if (!lvl && key_level[idx]) begin
        release_cnt[idx] = REL_LOAD;
      end
      key_level[idx] = lvl;
    end else begin
      // timer tick: walk every key in order
      for (k = 0; k < KEY_COUNT; k++) begin
        if (release_cnt[k] == REL_FIRE) begin
          release_key(k);
          stage_report();
        end
        release_cnt[k] = release_cnt[k] >> 1;
      end
    end
    if (staged_ok) begin
      staged.last = 1'b1;
      due_q.push_back(staged);
    end
  endtask

  task automatic check_report();
    report_t want;
    bit      bad;
    int      i;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX) begin
        $display("%0t: unexpected report %h last %b", $time, out_tdata, out_tlast);
      end
    end else begin
      want = due_q.pop_front();
      bad  = 1'b0;
      for (i = 0; i < QUEUE_LEN; i++) begin
        if (want.slots[i] !== out_tdata[i*SLOT_W +: SLOT_W]) bad = 1'b1;
      end
      if (want.mods !== out_tdata[QUEUE_LEN*SLOT_W +: SLOT_W]) bad = 1'b1;
      if (want.last !== out_tlast) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
          $display("%0t: report mismatch: expected slots %h mask %h last %b", $time,
                   want.slots, want.mods, want.last);
          $display("%0t:                  got      slots %h mask %h last %b", $time,
                   out_tdata[QUEUE_LEN*SLOT_W-1:0], out_tdata[QUEUE_LEN*SLOT_W +: SLOT_W],
                   out_tlast);
        end
      end
    end
  endtask

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        key_level[k]   = 1'b0;
        key_held[k]    = 1'b0;
        release_cnt[k] = '0;
        held_code[k]   = '0;
      end
      for (int s = 0; s < QUEUE_LEN; s++) rollover[s] = EMPTY_SLOT;
      mod_bits   = '0;
      mismatches = 0;
      due_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        apply_item(in_tuser, in_tdata[5:0], in_tdata[6], in_tdata[22:7]);
      end
      if (out_tvalid && out_tready) begin
        check_report();
      end
    end
    reports_due = due_q.size();
  end

endmodule

/* sim/tb_key_matrix_debounce_rollover_unit.sv */
`timescale 1ns / 100ps

module tb_key_matrix_debounce_rollover_unit;
  import kmdr_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // clearing pass and a stalled tick walk fit many times
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 34;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;    // key_index[5:0], key_level[6], key_code[22:7], zero pad
  logic        in_tuser   = 1'b0;  // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;          // slot_a..slot_f (8b each), modifier_mask[55:48]
  logic        out_tlast;          // last_report

  int   mismatches;
  int   reports_due;
  logic in_fire       = 1'b0;
  int   in_gap_pct    = 0;
  int   out_stall_pct = 0;
  int   quiet_cycles  = 0;
  logic lvl_seen [KEY_COUNT];

  always #4 clk = ~clk;

  key_matrix_debounce_rollover_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  kmdr_report_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  // Input handshake seen at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one item and hold it until accepted
  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx, input logic lvl,
                           input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {1'b0, code, lvl, idx};
    if (!cmd) lvl_seen[idx] = lvl;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
  endtask

  task automatic sample(input logic [IDX_W-1:0] idx, input logic lvl,
                        input logic [CODE_W-1:0] code);
    send_item(1'b0, idx, lvl, code);
  endtask

  // Tick with junk in the unused fields
  task automatic tick();
    send_item(1'b1, IDX_W'($urandom_range(KEY_COUNT-1)), 1'($urandom_range(1)),
              CODE_W'($urandom_range(65535)));
  endtask

  // Mostly level toggles on a small key pool so presses and releases collide
  task automatic random_item();
    logic [IDX_W-1:0]  idx;
    logic              lvl;
    logic [CODE_W-1:0] code;
    if ($urandom_range(99) < 35) begin
      tick();
    end else begin
      idx = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(11))
                                      : IDX_W'($urandom_range(KEY_COUNT-1));
      lvl = ($urandom_range(99) < 80) ? !lvl_seen[idx] : 1'($urandom_range(1));
      case ($urandom_range(3))
        0:       code = {CODE_MOD[15:8], 8'h01 << $urandom_range(7)};
        1:       code = CODE_W'($urandom_range(65535)) | CODE_LOCK;
        default: code = CODE_W'($urandom_range(65535));
      endcase
      sample(idx, lvl, code);
    end
  endtask

  // Hold the sender off until every predicted report is out
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  initial begin
    int ph;
    for (int k = 0; k < KEY_COUNT; k++) lvl_seen[k] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // regular, modifier with all bits, lock
    sample(6'd0, 1'b1, 16'h0004);
    sample(6'd63, 1'b1, 16'h01FF);
    sample(6'd5, 1'b1, 16'h0439);
    // six more regular keys push key 0 out of the queue
    sample(6'd1, 1'b1, 16'h0005);
    sample(6'd2, 1'b1, 16'h0006);
    sample(6'd3, 1'b1, 16'h2A07);
    sample(6'd4, 1'b1, 16'hFBFF);
    sample(6'd6, 1'b1, 16'h0200);
    sample(6'd7, 1'b1, 16'h8008);
    // falling edges: dropped key, modifier, lock, middle of queue
    sample(6'd0, 1'b0, 16'h0000);
    sample(6'd63, 1'b0, 16'h0000);
    sample(6'd5, 1'b0, 16'h0000);
    sample(6'd3, 1'b0, 16'h0000);
    // bounce on a held key cancels, then the fall reloads
    sample(6'd3, 1'b1, 16'h1234);
    sample(6'd3, 1'b0, 16'h0000);
    // level unchanged: no press
    sample(6'd7, 1'b1, 16'hFFFF);
    // seven silent ticks, the eighth releases four keys
    repeat (8) tick();
    sample(6'd10, 1'b1, 16'hFFFF);

    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_gap_pct = 47; out_stall_pct = 0;  end
        2:       begin in_gap_pct = 0;  out_stall_pct = 47; end
        default: begin in_gap_pct = 13; out_stall_pct = 13; end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/kmdr_pkg.sv
rtl/kmdr_ram.sv
rtl/kmdr_report.sv
rtl/key_matrix_debounce_rollover_unit.sv
sim/kmdr_report_checker.sv
sim/tb_key_matrix_debounce_rollover_unit.sv
